// ===== hdl/wcc_pkg.sv =====
// shared constants, codes and command/status types for the co-occurrence counter
`default_nettype none

package wcc_pkg;

   localparam int VOCAB_DEFAULT      = 256;
   localparam int MAX_WINDOW_DEFAULT = 8;

   localparam int WORD_W    = 8;
   localparam int COUNT_W   = 32;
   localparam int WINDOW_W  = 4;
   localparam int SENT_W    = 16;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DAT_W = 16;

   localparam logic [WINDOW_W-1:0] WINDOW_RESET   = 4'd5;
   localparam logic [SENT_W-1:0]   MAX_SENT_RESET = 16'd1000;

   // register indexes on the csr port
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_SIZE  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_SENTENCE = 1'b1;

   // request command codes
   localparam logic CMD_PUSH = 1'b0;
   localparam logic CMD_READ = 1'b1;

   typedef struct packed {
      logic load;        // capture the incoming request
      logic clr_write;   // clearing pass: zero one entry and advance
      logic end_sent;    // sentence end token
      logic start_push;  // set up the neighbour walk
      logic mem_rd;      // read the count memory
      logic rd_swap;     // address (current, earlier) instead of (earlier, current)
      logic rd_cell;     // address the requested cell
      logic mem_wr;      // write back the incremented count
      logic next_pair;   // step to the next earlier word
      logic commit;      // shift history, update sentence length
      logic rsp_load;    // load the response register
   } cmd_type;

   typedef struct packed {
      logic clr_done;
      logic is_read;
      logic word_zero;
      logic word_ok;
      logic pair_done;
      logic rsp_busy;
   } stat_type;

endpackage

`default_nettype wire

// ===== hdl/wcc_ctrl.sv =====
// controller state machine for the co-occurrence counter
`default_nettype none

module wcc_ctrl (
   input  wire                clock,
   input  wire                reset,
   input  wire                req_valid,
   output logic               req_stall,
   input  wcc_pkg::stat_type  stat,
   output wcc_pkg::cmd_type   cmd
);

   localparam logic [3:0] ST_CLEAR   = 4'd0;
   localparam logic [3:0] ST_IDLE    = 4'd1;
   localparam logic [3:0] ST_DECODE  = 4'd2;
   localparam logic [3:0] ST_RD_CELL = 4'd3;
   localparam logic [3:0] ST_RSP     = 4'd4;
   localparam logic [3:0] ST_PAIR    = 4'd5;
   localparam logic [3:0] ST_WR_A    = 4'd6;
   localparam logic [3:0] ST_RD_B    = 4'd7;
   localparam logic [3:0] ST_WR_B    = 4'd8;

   logic [3:0] state_ff;
   logic [3:0] state_in;

   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clr_write = 1'b1;
            if (stat.clr_done) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            if (stat.is_read) begin
               state_in = ST_RD_CELL;
            end else if (stat.word_zero) begin
               cmd.end_sent = 1'b1;
               state_in     = ST_IDLE;
            end else if (!stat.word_ok) begin
               state_in = ST_IDLE;
            end else begin
               cmd.start_push = 1'b1;
               state_in       = ST_PAIR;
            end
         end
         ST_RD_CELL: begin
            cmd.mem_rd  = 1'b1;
            cmd.rd_cell = 1'b1;
            state_in    = ST_RSP;
         end
         ST_RSP: begin
            if (!stat.rsp_busy) begin
               cmd.rsp_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_PAIR: begin
            if (stat.pair_done) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end else begin
               cmd.mem_rd = 1'b1;
               state_in   = ST_WR_A;
            end
         end
         ST_WR_A: begin
            cmd.mem_wr = 1'b1;
            state_in   = ST_RD_B;
         end
         ST_RD_B: begin
            cmd.mem_rd  = 1'b1;
            cmd.rd_swap = 1'b1;
            state_in    = ST_WR_B;
         end
         ST_WR_B: begin
            cmd.mem_wr    = 1'b1;
            cmd.next_pair = 1'b1;
            state_in      = ST_PAIR;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // every write-back follows the read of the same cell
   a_wr_after_rd: assert property (@(posedge clock) disable iff (reset)
      cmd.mem_wr |-> $past(cmd.mem_rd))
      else $error("count write without preceding read");

   // clearing pass and increments never share the write port
   a_clr_excl: assert property (@(posedge clock) disable iff (reset)
      cmd.clr_write |-> !cmd.mem_wr && !cmd.load)
      else $error("clear write overlaps other activity");

   // a response is only loaded into a free output register
   a_rsp_free: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> !stat.rsp_busy)
      else $error("response register overwritten");

endmodule

`default_nettype wire

// ===== hdl/wcc_dp.sv =====
// datapath: config registers, word history, count memory and response register
`default_nettype none

module wcc_dp #(
   parameter int VOCAB      = wcc_pkg::VOCAB_DEFAULT,
   parameter int MAX_WINDOW = wcc_pkg::MAX_WINDOW_DEFAULT
) (
   input  wire                                   clock,
   input  wire                                   reset,
   input  wcc_pkg::cmd_type                      cmd,
   output wcc_pkg::stat_type                     stat,
   input  wire                                   req_command,
   input  wire  [wcc_pkg::WORD_W-1:0]            req_word,
   input  wire  [wcc_pkg::WORD_W-1:0]            req_row,
   input  wire  [wcc_pkg::WORD_W-1:0]            req_col,
   output logic                                  rsp_valid,
   input  wire                                   rsp_stall,
   output logic [wcc_pkg::COUNT_W-1:0]           rsp_count,
   input  wire                                   csr_write_en,
   input  wire  [wcc_pkg::CSR_IDX_W-1:0]         csr_index,
   input  wire  [wcc_pkg::CSR_DAT_W-1:0]         csr_wdata
);

   localparam int VB  = $clog2(VOCAB);
   localparam int AW  = 2 * VB;
   localparam int CW  = $clog2(MAX_WINDOW + 1);
   localparam int HIW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;

   localparam int WW = wcc_pkg::WORD_W;
   localparam int NW = wcc_pkg::COUNT_W;
   localparam int SW = wcc_pkg::SENT_W;

   // configuration
   logic [wcc_pkg::WINDOW_W-1:0] cfg_window_ff;
   logic [SW-1:0]                cfg_max_sent_ff;

   // captured request
   logic          req_cmd_ff;
   logic [WW-1:0] word_ff;
   logic [WW-1:0] row_ff;
   logic [WW-1:0] col_ff;

   // sentence state
   logic [WW-1:0] hist_ff [MAX_WINDOW];
   logic [CW-1:0] fill_ff, fill_in;
   logic [SW-1:0] sent_len_ff, sent_len_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [CW-1:0] k_ff, k_in;
   logic [CW-1:0] win_cap;

   // count memory
   logic [NW-1:0] count_mem [2**AW];
   logic [AW-1:0] clr_addr_ff;
   logic [AW-1:0] addr_ff;
   logic [AW-1:0] rd_addr;
   logic [AW-1:0] wr_addr;
   logic [NW-1:0] wr_data;
   logic          mem_we;
   logic [NW-1:0] rdata_ff;
   logic [NW-1:0] rdata_inc;

   logic [WW-1:0] hist_e;
   logic [VB-1:0] e_ix, w_ix, r_ix, c_ix;
   logic          cell_ok;

   logic          rsp_valid_ff, rsp_valid_in;
   logic [NW-1:0] rsp_count_ff;

   logic [SW:0]   sent_next;
   logic [SW:0]   sent_limit;

   // config writes
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_window_ff   <= wcc_pkg::WINDOW_RESET;
         cfg_max_sent_ff <= wcc_pkg::MAX_SENT_RESET;
      end else if (csr_write_en) begin
         case (csr_index)
            wcc_pkg::CSR_WINDOW_SIZE:  cfg_window_ff   <= csr_wdata[wcc_pkg::WINDOW_W-1:0];
            wcc_pkg::CSR_MAX_SENTENCE: cfg_max_sent_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // request capture
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_cmd_ff <= req_command;
         word_ff    <= req_word;
         row_ff     <= req_row;
         col_ff     <= req_col;
      end
   end

   assign hist_e  = hist_ff[cnt_ff[HIW-1:0]];
   assign e_ix    = VB'(hist_e);
   assign w_ix    = VB'(word_ff);
   assign r_ix    = VB'(row_ff);
   assign c_ix    = VB'(col_ff);
   assign cell_ok = (32'(row_ff) < 32'(VOCAB)) && (32'(col_ff) < 32'(VOCAB));

   // neighbour cap: min(window, MAX_WINDOW); start_push then also limits it to fill
   always_comb begin
      if (32'(cfg_window_ff) > 32'(MAX_WINDOW)) begin
         win_cap = CW'(MAX_WINDOW);
      end else begin
         win_cap = CW'(cfg_window_ff);
      end
   end

   assign sent_next  = {1'b0, sent_len_ff} + {{SW{1'b0}}, 1'b1};
   // a zero limit behaves as one
   assign sent_limit = (cfg_max_sent_ff == '0) ? {{SW{1'b0}}, 1'b1} : {1'b0, cfg_max_sent_ff};

   always_comb begin
      cnt_in      = cnt_ff;
      k_in        = k_ff;
      fill_in     = fill_ff;
      sent_len_in = sent_len_ff;
      if (cmd.start_push) begin
         cnt_in = '0;
         k_in   = (win_cap > fill_ff) ? fill_ff : win_cap;
      end
      if (cmd.next_pair) begin
         cnt_in = cnt_ff + CW'(1);
      end
      if (cmd.end_sent) begin
         fill_in     = '0;
         sent_len_in = '0;
      end
      if (cmd.commit) begin
         if (sent_next >= sent_limit) begin
            fill_in     = '0;
            sent_len_in = '0;
         end else begin
            sent_len_in = sent_next[SW-1:0];
            if (32'(fill_ff) < 32'(MAX_WINDOW)) begin
               fill_in = fill_ff + CW'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff      <= '0;
         k_ff        <= '0;
         fill_ff     <= '0;
         sent_len_ff <= '0;
      end else begin
         cnt_ff      <= cnt_in;
         k_ff        <= k_in;
         fill_ff     <= fill_in;
         sent_len_ff <= sent_len_in;
      end
   end

   // most recent word sits at entry 0
   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         for (int i = MAX_WINDOW - 1; i > 0; i--) begin
            hist_ff[i] <= hist_ff[i-1];
         end
         hist_ff[0] <= word_ff;
      end
   end

   // clearing pass address
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_addr_ff <= '0;
      end else if (cmd.clr_write) begin
         clr_addr_ff <= clr_addr_ff + AW'(1);
      end
   end

   always_comb begin
      if (cmd.rd_cell) begin
         rd_addr = {r_ix, c_ix};
      end else if (cmd.rd_swap) begin
         rd_addr = {w_ix, e_ix};
      end else begin
         rd_addr = {e_ix, w_ix};
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.mem_rd) begin
         addr_ff <= rd_addr;
      end
   end

   // saturating increment
   assign rdata_inc = (rdata_ff == '1) ? rdata_ff : rdata_ff + NW'(1);

   assign mem_we  = cmd.clr_write | cmd.mem_wr;
   assign wr_addr = cmd.clr_write ? clr_addr_ff : addr_ff;
   assign wr_data = cmd.clr_write ? '0 : rdata_inc;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         count_mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.mem_rd) begin
         rdata_ff <= count_mem[rd_addr];
      end
   end

   // response register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && !rsp_stall) rsp_valid_in = 1'b0;
      if (cmd.rsp_load) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_count_ff <= cell_ok ? rdata_ff : '0;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_count = rsp_count_ff;

   always_comb begin
      stat.clr_done  = &clr_addr_ff;
      stat.is_read   = (req_cmd_ff == wcc_pkg::CMD_READ);
      stat.word_zero = (word_ff == '0);
      stat.word_ok   = (32'(word_ff) < 32'(VOCAB));
      stat.pair_done = (cnt_ff == k_ff);
      stat.rsp_busy  = rsp_valid_ff & rsp_stall;
   end

   // walk index never passes the neighbour count
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= k_ff)
      else $error("neighbour index beyond window");

   // history fill stays within the history depth
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      32'(fill_ff) <= 32'(MAX_WINDOW))
      else $error("history fill overflow");

   // a new walk never pairs with more words than the history holds
   a_k_fill: assert property (@(posedge clock) disable iff (reset)
      cmd.start_push |=> k_ff <= $past(fill_ff))
      else $error("window exceeds history fill");

endmodule

`default_nettype wire

// ===== hdl/window_cooccurrence_counter.sv =====
// top level: word co-occurrence window counter
// sequence: a read request passes decode, the cell read and the response state before
//   rsp_valid rises (later while an earlier response still waits), and the input is free
//   again when the response is loaded; a push walks k earlier neighbours (k up to window_size)
// throughput: one request at a time; each neighbour costs two read-modify-write
//   increments on the count memory, one per ordering of the two words
// reset: synchronous; a clearing pass then zeroes all 2**(2*ceil(log2(VOCAB))) entries
//   of the count memory (65536 at VOCAB 256), one entry a cycle, req_stall high
`default_nettype none

module window_cooccurrence_counter #(
   parameter int VOCAB      = wcc_pkg::VOCAB_DEFAULT,
   parameter int MAX_WINDOW = wcc_pkg::MAX_WINDOW_DEFAULT
) (
   input  wire                                   clock,
   input  wire                                   reset,
   input  wire                                   req_valid,
   output logic                                  req_stall,
   input  wire                                   req_command,
   input  wire  [wcc_pkg::WORD_W-1:0]            req_word,
   input  wire  [wcc_pkg::WORD_W-1:0]            req_row,
   input  wire  [wcc_pkg::WORD_W-1:0]            req_col,
   output logic                                  rsp_valid,
   input  wire                                   rsp_stall,
   output logic [wcc_pkg::COUNT_W-1:0]           rsp_count,
   input  wire                                   csr_write_en,
   input  wire  [wcc_pkg::CSR_IDX_W-1:0]         csr_index,
   input  wire  [wcc_pkg::CSR_DAT_W-1:0]         csr_wdata
);

   wcc_pkg::cmd_type  cmd;
   wcc_pkg::stat_type stat;

   wcc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   wcc_dp #(
      .VOCAB      (VOCAB),
      .MAX_WINDOW (MAX_WINDOW)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .stat         (stat),
      .req_command  (req_command),
      .req_word     (req_word),
      .req_row      (req_row),
      .req_col      (req_col),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_count    (rsp_count),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

endmodule

`default_nettype wire

// ===== bench/tb.sv =====
// self-checking bench for the word co-occurrence window counter
`timescale 1ns / 100ps

module tb;
   import wcc_pkg::*;

   localparam int CELLS      = VOCAB_DEFAULT * VOCAB_DEFAULT;
   localparam int PHASES     = 7;
   localparam int PHASE_LEN  = 278;
   localparam int POOL_SIZE  = 6;
   localparam int SETTLE     = 40;   // room for the longest push, with a full window of neighbours, to finish

   typedef struct packed {
      logic              command;
      logic [WORD_W-1:0] word;
      logic [WORD_W-1:0] row;
      logic [WORD_W-1:0] col;
   } word_request_type;

   // tracks the count matrix and sentence window, queues the counts reads must return
   class cooccur_tracker;
      bit   [COUNT_W-1:0]  cells [CELLS];
      logic [WORD_W-1:0]   recent_words [MAX_WINDOW_DEFAULT];
      int unsigned         recent_fill;
      int unsigned         sentence_words;
      logic [WINDOW_W-1:0] window;
      logic [SENT_W-1:0]   sentence_limit;
      logic [COUNT_W-1:0]  expected_counts [$];
      int unsigned         error_count;

      function new();
         foreach (recent_words[i]) recent_words[i] = '0;
         recent_fill    = 0;
         sentence_words = 0;
         window         = WINDOW_RESET;
         sentence_limit = MAX_SENT_RESET;
         error_count    = 0;
      endfunction

      function void set_register(logic [CSR_IDX_W-1:0] idx, logic [CSR_DAT_W-1:0] value);
         if (idx == CSR_WINDOW_SIZE) begin
            window = value[WINDOW_W-1:0];
         end else begin
            sentence_limit = value[SENT_W-1:0];
         end
      endfunction

      function void bump(logic [WORD_W-1:0] r, logic [WORD_W-1:0] c);
         if (cells[{r, c}] != '1) begin
            cells[{r, c}]++;
         end
      endfunction

      function void note_request(word_request_type req);
         int unsigned pairs;
         int unsigned limit;
         int          i;
         if (req.command == CMD_READ) begin
            expected_counts.push_back(cells[{req.row, req.col}]);
            return;
         end
         if (req.word == '0) begin
            recent_fill    = 0;
            sentence_words = 0;
            return;
         end
         // oversized window clamps, then only words of this sentence count
         pairs = (window > MAX_WINDOW_DEFAULT) ? MAX_WINDOW_DEFAULT : window;
         if (pairs > recent_fill) pairs = recent_fill;
         for (i = 0; i < pairs; i++) begin
            bump(recent_words[i], req.word);
            bump(req.word, recent_words[i]);
         end
         for (i = MAX_WINDOW_DEFAULT - 1; i > 0; i--) begin
            recent_words[i] = recent_words[i-1];
         end
         recent_words[0] = req.word;
         if (recent_fill < MAX_WINDOW_DEFAULT) recent_fill++;
         sentence_words++;
         limit = (sentence_limit == '0) ? 1 : sentence_limit;
         if (sentence_words >= limit) begin
            recent_fill    = 0;
            sentence_words = 0;
         end
      endfunction

      task report_mismatch(string msg);
         $display("mismatch: %s", msg);
         error_count++;
      endtask

      task check_count(logic [COUNT_W-1:0] got);
         logic [COUNT_W-1:0] want;
         if (expected_counts.size() == 0) begin
            report_mismatch($sformatf("count %0d with no read outstanding", got));
         end else begin
            want = expected_counts.pop_front();
            if (got !== want) begin
               report_mismatch($sformatf("count %0d, expected %0d", got, want));
            end
         end
      endtask

      task check_drained();
         if (expected_counts.size() != 0) begin
            report_mismatch($sformatf("%0d reads never answered", expected_counts.size()));
         end
      endtask
   endclass

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic                 req_command = CMD_PUSH;
   logic [WORD_W-1:0]    req_word = '0;
   logic [WORD_W-1:0]    req_row = '0;
   logic [WORD_W-1:0]    req_col = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic [COUNT_W-1:0]   rsp_count;
   logic                 csr_write_en = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = CSR_WINDOW_SIZE;
   logic [CSR_DAT_W-1:0] csr_wdata = '0;

   cooccur_tracker       tracker;
   int unsigned          send_idle_pct = 28;
   int unsigned          recv_idle_pct = 64;
   logic [WORD_W-1:0]    word_pool [POOL_SIZE];

   int unsigned phase_window [PHASES] = '{1, 8, 0, 15, 9, 2, 7};
   int unsigned phase_limit  [PHASES] = '{65535, 6, 1000, 40, 100, 0, 3};

   window_cooccurrence_counter dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_command  (req_command),
      .req_word     (req_word),
      .req_row      (req_row),
      .req_col      (req_col),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_count    (rsp_count),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_idle_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         tracker.check_count(rsp_count);
      end
   end

   function automatic word_request_type push_req(logic [WORD_W-1:0] w);
      word_request_type r;
      r.command = CMD_PUSH;
      r.word    = w;
      r.row     = WORD_W'($urandom);
      r.col     = WORD_W'($urandom);
      return r;
   endfunction

   function automatic word_request_type read_req(logic [WORD_W-1:0] r_idx,
                                                 logic [WORD_W-1:0] c_idx);
      word_request_type r;
      r.command = CMD_READ;
      r.word    = WORD_W'($urandom);
      r.row     = r_idx;
      r.col     = c_idx;
      return r;
   endfunction

   // small word pool per phase so cells fill up; a share of full-range words and reads
   function automatic word_request_type random_request();
      int unsigned pick;
      pick = $urandom_range(99);
      if (pick < 30) begin
         if ($urandom_range(9) < 7) begin
            return read_req(word_pool[$urandom_range(POOL_SIZE-1)],
                            word_pool[$urandom_range(POOL_SIZE-1)]);
         end
         return read_req(WORD_W'($urandom), WORD_W'($urandom));
      end
      if (pick < 39) return push_req('0);
      if (pick < 47) return push_req(WORD_W'($urandom));
      return push_req(word_pool[$urandom_range(POOL_SIZE-1)]);
   endfunction

   task automatic send_request(input word_request_type r);
      int unsigned gap;
      req_valid   <= 1'b1;
      req_command <= r.command;
      req_word    <= r.word;
      req_row     <= r.row;
      req_col     <= r.col;
      do @(posedge clock); while (req_stall);
      tracker.note_request(r);
      gap = 0;
      while ($urandom_range(99) < send_idle_pct) gap++;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // hold off new requests until every read has answered, then idle for the extra cycles asked
   task automatic drain_counts(input int unsigned extra);
      req_valid <= 1'b0;
      while (tracker.expected_counts.size() != 0) @(posedge clock);
      repeat (extra) @(posedge clock);
   endtask

   task automatic write_settings(input int unsigned win, input int unsigned limit);
      csr_write_en <= 1'b1;
      csr_index    <= CSR_WINDOW_SIZE;
      csr_wdata    <= CSR_DAT_W'(win);
      tracker.set_register(CSR_WINDOW_SIZE, CSR_DAT_W'(win));
      @(posedge clock);
      csr_index    <= CSR_MAX_SENTENCE;
      csr_wdata    <= CSR_DAT_W'(limit);
      tracker.set_register(CSR_MAX_SENTENCE, CSR_DAT_W'(limit));
      @(posedge clock);
      csr_write_en <= 1'b0;
   endtask

   task automatic run_directed();
      send_request(push_req(8'd10));
      send_request(push_req(8'd20));
      send_request(push_req(8'd30));
      // fourth word hits the sentence limit
      send_request(push_req(8'd40));
      send_request(push_req(8'd50));
      send_request(read_req(8'd10, 8'd20));
      send_request(read_req(8'd40, 8'd10));
      send_request(read_req(8'd40, 8'd50));
      send_request(push_req(8'd0));
      // same word twice bumps its diagonal cell twice
      send_request(push_req(8'd7));
      send_request(push_req(8'd7));
      send_request(read_req(8'd7, 8'd7));
      send_request(push_req(8'd255));
      send_request(push_req(8'd1));
      send_request(read_req(8'd255, 8'd1));
      send_request(read_req(8'd1, 8'd255));
      send_request(read_req(8'd0, 8'd255));
      send_request(read_req(8'd255, 8'd0));
      send_request(read_req(8'd255, 8'd255));
      send_request(push_req(8'd0));
      send_request(push_req(8'd0));
      send_request(read_req(8'd0, 8'd0));
   endtask

   initial begin
      int unsigned issued;
      int          ph;
      int          n;
      int          i;
      tracker = new();
      issued  = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      write_settings(3, 4);
      run_directed();
      for (ph = 0; ph < PHASES; ph++) begin
         drain_counts(SETTLE);
         write_settings(phase_window[ph], phase_limit[ph]);
         for (i = 0; i < POOL_SIZE; i++) begin
            word_pool[i] = WORD_W'($urandom_range(255, 1));
         end
         for (n = 0; n < PHASE_LEN; n++) begin
            if (issued < PHASES * PHASE_LEN / 3) begin
               send_idle_pct = 28;
               recv_idle_pct = 64;
            end else if (issued < 2 * PHASES * PHASE_LEN / 3) begin
               send_idle_pct = 64;
               recv_idle_pct = 28;
            end else begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
            if (ph == 1 && n == PHASE_LEN / 2) drain_counts(1);
            send_request(random_request());
            issued++;
         end
      end
      drain_counts(SETTLE);
      tracker.check_drained();
      if (tracker.error_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   initial begin
      #(64'd30_000_000);
      $display("simulation failed");
      $finish;
   end

endmodule
